/* rtl/sce_pkg.sv */
// Shared types, constants and helper functions of the simple CPU execute unit.
package sce_pkg;

   // Data path and field widths.
   localparam int XLEN       = 32;
   localparam int NUM_REGS   = 16;
   localparam int REG_AW     = 4;
   localparam int OP_W       = 5;
   localparam int PC_W       = 12;
   localparam int INSTR_W    = 20;
   localparam int PRELOAD_AW = 12;
   localparam int CYC_INC_W  = 2;

   // Default data memory depth in words; the depth is a power of two.
   localparam int MEM_WORDS = 4096;

   // Item kinds carried by the func field.
   localparam logic FUNC_EXEC    = 1'b0;
   localparam logic FUNC_PRELOAD = 1'b1;

   // Fixed register numbers.
   localparam logic [REG_AW-1:0] REG_ZERO = 4'd0;
   localparam logic [REG_AW-1:0] REG_IMM  = 4'd1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_AND  = 5'd3,
      OP_OR   = 5'd4,
      OP_XOR  = 5'd5,
      OP_SLL  = 5'd6,
      OP_SRA  = 5'd7,
      OP_SRL  = 5'd8,
      OP_BEQ  = 5'd9,
      OP_BNE  = 5'd10,
      OP_BLT  = 5'd11,
      OP_BGT  = 5'd12,
      OP_BLE  = 5'd13,
      OP_BGE  = 5'd14,
      OP_JAL  = 5'd15,
      OP_LW   = 5'd16,
      OP_SW   = 5'd17,
      OP_RETI = 5'd18,
      OP_IN   = 5'd19,
      OP_OUT  = 5'd20,
      OP_HALT = 5'd21
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ILLEGAL = 2'd1,
      STATUS_HALTED  = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   // Register file write port.
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } rf_write_type;

   // Register file read addresses and read data for rs, rt and rd.
   typedef struct packed {
      logic [REG_AW-1:0] a;
      logic [REG_AW-1:0] b;
      logic [REG_AW-1:0] d;
   } rf_read_addr_type;

   typedef struct packed {
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] d;
   } rf_read_data_type;

   // Opcodes whose destination is checked against registers 0 and 1.
   function automatic logic op_checks_dest(input op_type op);
      return op inside {[OP_ADD:OP_SRL], OP_JAL, OP_LW, OP_IN};
   endfunction

   // Opcodes that write the destination register.
   function automatic logic op_writes_reg(input op_type op);
      return op inside {[OP_ADD:OP_SRL], OP_JAL, OP_LW};
   endfunction

   // Arithmetic right shift; amounts of 32 or more fill with the sign bit.
   function automatic logic [XLEN-1:0] shift_sra(input logic [XLEN-1:0] value,
                                                  input logic [XLEN-1:0] amount);
      logic [XLEN-1:0] result;
      if (|amount[XLEN-1:5]) begin
         result = {XLEN{value[XLEN-1]}};
      end else begin
         result = XLEN'($signed(value) >>> amount[4:0]);
      end
      return result;
   endfunction

endpackage

/* rtl/sce_regfile.sv */
// Register file: two identical banks giving three registered read ports.
module sce_regfile (
   input  logic                         clock,
   input  logic                         reset,
   input  sce_pkg::rf_write_type        wr,
   input  sce_pkg::rf_read_addr_type    raddr,
   output sce_pkg::rf_read_data_type    rdata
);

   logic [sce_pkg::XLEN-1:0]     bank_ab [sce_pkg::NUM_REGS];
   logic [sce_pkg::XLEN-1:0]     bank_d  [sce_pkg::NUM_REGS];
   logic [sce_pkg::NUM_REGS-1:0] valid_ff;
   logic [sce_pkg::XLEN-1:0]     q_a_ff;
   logic [sce_pkg::XLEN-1:0]     q_b_ff;
   logic [sce_pkg::XLEN-1:0]     q_d_ff;
   logic                         qv_a_ff;
   logic                         qv_b_ff;
   logic                         qv_d_ff;

   // Written flags: an entry never written reads as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Both banks take every write; reads return the contents before the edge.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         bank_ab[wr.addr] <= wr.data;
         bank_d[wr.addr]  <= wr.data;
      end
      q_a_ff  <= bank_ab[raddr.a];
      q_b_ff  <= bank_ab[raddr.b];
      q_d_ff  <= bank_d[raddr.d];
      qv_a_ff <= valid_ff[raddr.a];
      qv_b_ff <= valid_ff[raddr.b];
      qv_d_ff <= valid_ff[raddr.d];
   end

   assign rdata.a = qv_a_ff ? q_a_ff : '0;
   assign rdata.b = qv_b_ff ? q_b_ff : '0;
   assign rdata.d = qv_d_ff ? q_d_ff : '0;

endmodule

/* rtl/simple_cpu_execute_unit.sv */
// Top level of the simple CPU execute unit: two-stage pipeline around the memories.
// Each request is taken into stage 1, executed there, and registered into stage 2, where its result is offered.
// Throughput: one item per cycle while rsp_stall is low; each item makes one pass through
// the register file read ports and at most one access on the single data memory port.
// Reset clears the pipeline, PC, cycle count, halt flag and register written flags;
// the data memory is not cleared and holds no defined value until written.
module simple_cpu_execute_unit #(
   parameter int MEM_WORDS = sce_pkg::MEM_WORDS
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [sce_pkg::OP_W-1:0]        req_opcode,
   input  logic [sce_pkg::REG_AW-1:0]      req_dest_reg,
   input  logic [sce_pkg::REG_AW-1:0]      req_src_reg_a,
   input  logic [sce_pkg::REG_AW-1:0]      req_src_reg_b,
   input  logic signed [sce_pkg::XLEN-1:0] req_immediate,
   input  logic [sce_pkg::PRELOAD_AW-1:0]  req_preload_addr,
   input  logic signed [sce_pkg::XLEN-1:0] req_preload_data,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sce_pkg::PC_W-1:0]        rsp_pc_value,
   output logic [sce_pkg::INSTR_W-1:0]     rsp_instr_word,
   output logic [sce_pkg::PC_W-1:0]        rsp_next_pc_value,
   output logic                            rsp_reg_write,
   output logic [sce_pkg::REG_AW-1:0]      rsp_written_reg,
   output logic signed [sce_pkg::XLEN-1:0] rsp_written_value,
   output logic [1:0]                      rsp_status,
   output logic [sce_pkg::XLEN-1:0]        rsp_cycle_count
);

   localparam int XLEN   = sce_pkg::XLEN;
   localparam int PC_W   = sce_pkg::PC_W;
   localparam int REG_AW = sce_pkg::REG_AW;
   localparam int MEM_AW = $clog2(MEM_WORDS);

   // Architectural control state.
   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic [XLEN-1:0] cycle_ff;
   logic [XLEN-1:0] cycle_in;
   logic            halted_ff;
   logic            halted_in;

   // Handshake.
   logic s1_load;
   logic s1_advance;
   logic rsp_xfer;

   // Decode done when the request is taken.
   logic                    acc_use_imm;
   logic                    acc_exec;
   logic                    acc_illegal;
   logic [sce_pkg::CYC_INC_W-1:0] acc_inc;

   // Stage 1: operands come back from the register file.
   logic                      s1_valid_ff;
   logic                      s1_func_ff;
   sce_pkg::op_type           s1_op_ff;
   logic [REG_AW-1:0]         s1_rd_ff;
   logic [REG_AW-1:0]         s1_rs_ff;
   logic [REG_AW-1:0]         s1_rt_ff;
   logic [XLEN-1:0]           s1_imm_ff;
   logic [sce_pkg::PRELOAD_AW-1:0] s1_paddr_ff;
   logic [XLEN-1:0]           s1_pdata_ff;
   logic                      s1_ignored_ff;
   logic                      s1_illegal_ff;
   logic                      s1_use_imm_ff;
   logic [XLEN-1:0]           s1_cycle_ff;

   // Stage 2: the result waiting for its transfer.
   logic                         s2_valid_ff;
   logic [PC_W-1:0]              s2_pc_ff;
   logic [sce_pkg::INSTR_W-1:0]  s2_instr_ff;
   logic [PC_W-1:0]              s2_next_pc_ff;
   logic                         s2_wr_ff;
   logic [REG_AW-1:0]            s2_wreg_ff;
   logic [XLEN-1:0]              s2_wval_ff;
   logic                         s2_is_lw_ff;
   sce_pkg::status_type          s2_status_ff;
   logic [XLEN-1:0]              s2_cycle_ff;

   // Most recent register file write, kept for the cycle after it lands.
   logic              wb_fresh_ff;
   logic [REG_AW-1:0] wb_reg_ff;
   logic [XLEN-1:0]   wb_val_ff;

   // Register file connections.
   sce_pkg::rf_write_type     rf_wr;
   sce_pkg::rf_read_addr_type rf_raddr;
   sce_pkg::rf_read_data_type rf_rdata;

   // Stage 1 execution results.
   logic [XLEN-1:0]   op_a;
   logic [XLEN-1:0]   op_b;
   logic [XLEN-1:0]   op_d;
   logic              ex_run;
   logic [PC_W-1:0]   seq_next;
   logic [PC_W-1:0]   ex_next_pc;
   logic [XLEN-1:0]   ex_value;
   logic              ex_wr;
   logic              ex_is_lw;
   sce_pkg::status_type ex_status;
   logic [sce_pkg::INSTR_W-1:0] ex_instr;
   logic [XLEN-1:0]   mem_sum;
   logic [XLEN-1:0]   preload_wide;

   // Data memory.
   logic [XLEN-1:0]   dmem [MEM_WORDS];
   logic [XLEN-1:0]   dmem_q_ff;
   logic              dm_we;
   logic              dm_re;
   logic [MEM_AW-1:0] dm_addr;
   logic [XLEN-1:0]   dm_wdata;

   // Operand selection: fixed registers, then the newest pending write.
   function automatic logic [XLEN-1:0] pick_operand(
      input logic [REG_AW-1:0] idx,
      input logic [XLEN-1:0]   rf_value,
      input logic [XLEN-1:0]   imm,
      input logic              s2_hit,
      input logic [REG_AW-1:0] s2_reg,
      input logic [XLEN-1:0]   s2_val,
      input logic              wb_hit,
      input logic [REG_AW-1:0] wb_reg,
      input logic [XLEN-1:0]   wb_val);
      logic [XLEN-1:0] value;
      if (idx == sce_pkg::REG_ZERO) begin
         value = '0;
      end else if (idx == sce_pkg::REG_IMM) begin
         value = imm;
      end else if (s2_hit && s2_reg == idx) begin
         value = s2_val;
      end else if (wb_hit && wb_reg == idx) begin
         value = wb_val;
      end else begin
         value = rf_value;
      end
      return value;
   endfunction

   // Handshake: stage 1 moves on when stage 2 is empty or being drained.
   assign rsp_xfer   = s2_valid_ff && !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign s1_load    = req_valid && !req_stall;

   // Decode the fields that the cycle count and halt flag depend on.
   always_comb begin
      acc_use_imm = (req_dest_reg == sce_pkg::REG_IMM) || (req_src_reg_a == sce_pkg::REG_IMM)
                 || (req_src_reg_b == sce_pkg::REG_IMM);
      acc_exec    = !halted_ff && (req_func == sce_pkg::FUNC_EXEC);
      acc_illegal = acc_exec && (req_dest_reg <= sce_pkg::REG_IMM)
                 && sce_pkg::op_checks_dest(sce_pkg::op_type'(req_opcode));
      acc_inc = '0;
      if (acc_exec) begin
         acc_inc = 2'd1 + {1'b0, acc_use_imm}
                 + {1'b0, !acc_illegal && (req_opcode == sce_pkg::OP_LW
                                        || req_opcode == sce_pkg::OP_SW)};
      end
      cycle_in  = cycle_ff + {{(XLEN-sce_pkg::CYC_INC_W){1'b0}}, acc_inc};
      halted_in = halted_ff || (acc_exec && req_opcode == sce_pkg::OP_HALT);
   end

   // Cycle counter and halt flag advance as each request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (s1_load) begin
         cycle_ff  <= cycle_in;
         halted_ff <= halted_in;
      end
   end

   // Stage 1 valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_func_ff    <= req_func;
         s1_op_ff      <= sce_pkg::op_type'(req_opcode);
         s1_rd_ff      <= req_dest_reg;
         s1_rs_ff      <= req_src_reg_a;
         s1_rt_ff      <= req_src_reg_b;
         s1_imm_ff     <= req_immediate;
         s1_paddr_ff   <= req_preload_addr;
         s1_pdata_ff   <= req_preload_data;
         s1_ignored_ff <= halted_ff;
         s1_illegal_ff <= acc_illegal;
         s1_use_imm_ff <= acc_use_imm;
         s1_cycle_ff   <= cycle_in;
      end
   end

   // The register file is read every cycle for the item that stage 1 holds next.
   always_comb begin
      if (s1_load) begin
         rf_raddr.a = req_src_reg_a;
         rf_raddr.b = req_src_reg_b;
         rf_raddr.d = req_dest_reg;
      end else begin
         rf_raddr.a = s1_rs_ff;
         rf_raddr.b = s1_rt_ff;
         rf_raddr.d = s1_rd_ff;
      end
   end

   // Write back when a result leaves stage 2.
   assign rf_wr.en   = rsp_xfer && s2_wr_ff;
   assign rf_wr.addr = s2_wreg_ff;
   assign rf_wr.data = rsp_written_value;

   sce_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .wr    (rf_wr),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   // Remember the write that the read at the same edge could not see.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_fresh_ff <= 1'b0;
      end else begin
         wb_fresh_ff <= rf_wr.en;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_wr.en) begin
         wb_reg_ff <= rf_wr.addr;
         wb_val_ff <= rf_wr.data;
      end
   end

   // Forwarded operands for stage 1.
   always_comb begin
      op_a = pick_operand(s1_rs_ff, rf_rdata.a, s1_imm_ff, s2_valid_ff && s2_wr_ff,
                          s2_wreg_ff, rsp_written_value, wb_fresh_ff, wb_reg_ff, wb_val_ff);
      op_b = pick_operand(s1_rt_ff, rf_rdata.b, s1_imm_ff, s2_valid_ff && s2_wr_ff,
                          s2_wreg_ff, rsp_written_value, wb_fresh_ff, wb_reg_ff, wb_val_ff);
      op_d = pick_operand(s1_rd_ff, rf_rdata.d, s1_imm_ff, s2_valid_ff && s2_wr_ff,
                          s2_wreg_ff, rsp_written_value, wb_fresh_ff, wb_reg_ff, wb_val_ff);
   end

   // Execute: ALU, branch resolution and status.
   always_comb begin
      ex_run     = !s1_ignored_ff && (s1_func_ff == sce_pkg::FUNC_EXEC) && !s1_illegal_ff;
      seq_next   = pc_ff + (s1_use_imm_ff ? PC_W'(2) : PC_W'(1));
      ex_value   = '0;
      ex_next_pc = seq_next;
      case (s1_op_ff)
         sce_pkg::OP_ADD: ex_value = op_a + op_b;
         sce_pkg::OP_SUB: ex_value = op_a - op_b;
         sce_pkg::OP_MUL: ex_value = op_a * op_b;
         sce_pkg::OP_AND: ex_value = op_a & op_b;
         sce_pkg::OP_OR:  ex_value = op_a | op_b;
         sce_pkg::OP_XOR: ex_value = op_a ^ op_b;
         sce_pkg::OP_SLL: ex_value = (|op_b[XLEN-1:5]) ? '0 : (op_a << op_b[4:0]);
         sce_pkg::OP_SRA: ex_value = sce_pkg::shift_sra(op_a, op_b);
         sce_pkg::OP_SRL: ex_value = (|op_b[XLEN-1:5]) ? '0 : (op_a >> op_b[4:0]);
         sce_pkg::OP_BEQ: if (op_a == op_b) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_BNE: if (op_a != op_b) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_BLT: if ($signed(op_a) < $signed(op_b)) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_BGT: if ($signed(op_a) > $signed(op_b)) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_BLE: if ($signed(op_a) <= $signed(op_b)) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_BGE: if ($signed(op_a) >= $signed(op_b)) ex_next_pc = op_d[PC_W-1:0];
         sce_pkg::OP_JAL: begin
            ex_value   = {{(XLEN-PC_W){1'b0}}, seq_next};
            ex_next_pc = op_a[PC_W-1:0];
         end
         default: ;
      endcase

      // An illegal destination still advances the PC sequentially.
      if (!ex_run) begin
         ex_next_pc = seq_next;
      end
      if (s1_ignored_ff || s1_func_ff == sce_pkg::FUNC_PRELOAD) begin
         ex_next_pc = pc_ff;
      end

      ex_wr    = ex_run && sce_pkg::op_writes_reg(s1_op_ff);
      ex_is_lw = ex_run && (s1_op_ff == sce_pkg::OP_LW);
      if (!ex_wr || ex_is_lw) begin
         ex_value = '0;
      end

      if (s1_ignored_ff) begin
         ex_status = sce_pkg::STATUS_IGNORED;
      end else if (s1_func_ff == sce_pkg::FUNC_PRELOAD) begin
         ex_status = sce_pkg::STATUS_OK;
      end else if (s1_illegal_ff) begin
         ex_status = sce_pkg::STATUS_ILLEGAL;
      end else if (s1_op_ff == sce_pkg::OP_HALT) begin
         ex_status = sce_pkg::STATUS_HALTED;
      end else begin
         ex_status = sce_pkg::STATUS_OK;
      end

      if (s1_ignored_ff || s1_func_ff == sce_pkg::FUNC_PRELOAD) begin
         ex_instr = '0;
      end else begin
         ex_instr = {{(sce_pkg::INSTR_W-sce_pkg::OP_W-3*REG_AW){1'b0}},
                     s1_op_ff, s1_rd_ff, s1_rs_ff, s1_rt_ff};
      end
   end

   // Data memory access on the stage 1 to stage 2 transfer; the depth is a power of two.
   always_comb begin
      mem_sum      = op_a + op_b;
      preload_wide = {{(XLEN-sce_pkg::PRELOAD_AW){1'b0}}, s1_paddr_ff};
      if (s1_func_ff == sce_pkg::FUNC_PRELOAD) begin
         dm_addr  = preload_wide[MEM_AW-1:0];
         dm_wdata = s1_pdata_ff;
      end else begin
         dm_addr  = mem_sum[MEM_AW-1:0];
         dm_wdata = op_d;
      end
      dm_we = s1_advance && !s1_ignored_ff
           && ((s1_func_ff == sce_pkg::FUNC_PRELOAD)
               || (ex_run && s1_op_ff == sce_pkg::OP_SW));
      dm_re = s1_advance && ex_is_lw;
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_addr] <= dm_wdata;
      end
      if (dm_re) begin
         dmem_q_ff <= dmem[dm_addr];
      end
   end

   // Program counter follows the items in order as they leave stage 1.
   assign pc_in = ex_next_pc;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (s1_advance) begin
         pc_ff <= pc_in;
      end
   end

   // Stage 2 valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // Stage 2 payload.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_pc_ff      <= pc_ff;
         s2_instr_ff   <= ex_instr;
         s2_next_pc_ff <= ex_next_pc;
         s2_wr_ff      <= ex_wr;
         s2_wreg_ff    <= ex_wr ? s1_rd_ff : sce_pkg::REG_ZERO;
         s2_wval_ff    <= ex_value;
         s2_is_lw_ff   <= ex_is_lw;
         s2_status_ff  <= ex_status;
         s2_cycle_ff   <= s1_cycle_ff;
      end
   end

   // Result outputs; a load takes its value from the data memory read register.
   assign rsp_valid         = s2_valid_ff;
   assign rsp_pc_value      = s2_pc_ff;
   assign rsp_instr_word    = s2_instr_ff;
   assign rsp_next_pc_value = s2_next_pc_ff;
   assign rsp_reg_write     = s2_wr_ff;
   assign rsp_written_reg   = s2_wreg_ff;
   assign rsp_written_value = s2_is_lw_ff ? dmem_q_ff : s2_wval_ff;
   assign rsp_status        = s2_status_ff;
   assign rsp_cycle_count   = s2_cycle_ff;

   // Registers 0 and 1 are never written back.
   assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (rf_wr.addr != sce_pkg::REG_ZERO && rf_wr.addr != sce_pkg::REG_IMM))
      else $error("register file write to a fixed register");

   // Once halted, the block stays halted until reset.
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped without reset");

   // An ignored item never writes a register or touches the data memory.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ignored_ff) |-> (!ex_wr && !dm_we && !dm_re))
      else $error("ignored item caused a side effect");

   // A load in stage 2 always reports a register write.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_is_lw_ff) |-> s2_wr_ff)
      else $error("load without register write");

   // Requests are held off only while stage 1 holds an item that cannot move.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

endmodule
